FILE: hw/rtl/gbp_pkg.sv
`default_nettype none

package gbp_pkg;

    // default sizes of the predictor
    localparam int INDEX_BITS_DEF   = 12;
    localparam int HISTORY_BITS_DEF = 2;

    // two-bit prediction counter
    typedef logic [1:0] t_ctr;

    localparam t_ctr CTR_STRONG_TAKEN = 2'd3;
    localparam t_ctr CTR_WEAK_TAKEN   = 2'd2;
    localparam t_ctr CTR_WEAK_NOT     = 2'd1;
    localparam t_ctr CTR_STRONG_NOT   = 2'd0;

    // value of every counter after reset
    localparam t_ctr CTR_RESET = CTR_STRONG_TAKEN;

    // counter update: both weak states jump to a strong state
    function automatic t_ctr next_ctr(input t_ctr cur, input logic taken);
        t_ctr res;
        case (cur)
            CTR_STRONG_TAKEN: res = taken ? CTR_STRONG_TAKEN : CTR_WEAK_TAKEN;
            CTR_WEAK_TAKEN:   res = taken ? CTR_STRONG_TAKEN : CTR_STRONG_NOT;
            CTR_WEAK_NOT:     res = taken ? CTR_STRONG_TAKEN : CTR_STRONG_NOT;
            default:          res = taken ? CTR_WEAK_NOT : CTR_STRONG_NOT;
        endcase
        return res;
    endfunction

    // taken prediction for a counter value
    function automatic logic ctr_taken(input t_ctr cur);
        return cur[1];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gbp_ram.sv
`default_nettype none

module gbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16384
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port; a read returns the old data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/global_history_branch_predictor.sv
// flow: an accepted request is registered in stage one with its counter read, then
//   moves to the output register behind o_valid whenever the output is not stalled
// throughput: one request per cycle while o_stall is low, set by the counter table's
//   read-modify-write on one write and one read port, bypassing a write at read time
// reset: history goes to all ones; a clearing pass then writes every counter to 3,
//   all 2^(HISTORY_BITS+INDEX_BITS) of them (16384 at defaults), with o_stall held high
`default_nettype none

module global_history_branch_predictor #(
    parameter int INDEX_BITS   = gbp_pkg::INDEX_BITS_DEF,
    parameter int HISTORY_BITS = gbp_pkg::HISTORY_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [31:0] i_branch_pc,
    input  wire         i_was_taken,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_predict_taken
);

    import gbp_pkg::*;

    localparam int TW    = HISTORY_BITS + INDEX_BITS;
    localparam int DEPTH = 1 << TW;

    logic [HISTORY_BITS-1:0] r_hist;
    logic [HISTORY_BITS-1:0] n_hist;
    logic [HISTORY_BITS:0]   hist_shift;
    logic                    r_s1_vld;
    logic [TW-1:0]           r_s1_idx;
    logic                    r_s1_taken;
    logic                    r_fwd_vld;
    t_ctr                    r_fwd_ctr;
    logic                    r_out_vld;
    logic                    r_out_pred;
    logic                    r_clr_act;
    logic [TW-1:0]           r_clr_idx;

    logic [TW-1:0]           in_idx;
    logic                    adv;
    logic                    s1_go;
    logic                    accept;
    t_ctr                    ram_rdata;
    t_ctr                    cur_ctr;
    t_ctr                    upd_ctr;
    logic                    ram_we;
    logic [TW-1:0]           ram_waddr;
    t_ctr                    ram_wdata;
    logic                    fwd_hit;

    // handshake and flow
    assign adv     = !r_out_vld || !i_stall;
    assign s1_go   = r_s1_vld && adv;
    assign o_stall = r_clr_act || (r_s1_vld && !adv);
    assign accept  = i_valid && !o_stall;

    // table index: history on top of the low pc bits
    assign in_idx = {r_hist, i_branch_pc[INDEX_BITS-1:0]};

    // history shifts right, new outcome enters at the msb
    assign hist_shift = {i_was_taken, r_hist};
    assign n_hist     = hist_shift[HISTORY_BITS:1];

    // counter read with bypass of the write made at read time
    assign cur_ctr = r_fwd_vld ? r_fwd_ctr : ram_rdata;
    assign upd_ctr = next_ctr(cur_ctr, r_s1_taken);

    // write port: clearing pass or counter update
    assign ram_we    = r_clr_act || s1_go;
    assign ram_waddr = r_clr_act ? r_clr_idx : r_s1_idx;
    assign ram_wdata = r_clr_act ? CTR_RESET : upd_ctr;
    assign fwd_hit   = s1_go && (r_s1_idx == in_idx);

    gbp_ram #(
        .WIDTH ($bits(t_ctr)),
        .DEPTH (DEPTH)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist    <= '1;
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_clr_act <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            if (r_clr_act) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    r_clr_act <= 1'b0;
                end
            end
            if (accept) begin
                r_hist    <= n_hist;
                r_fwd_vld <= fwd_hit;
            end else if (s1_go) begin
                r_fwd_vld <= 1'b0;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_idx   <= in_idx;
            r_s1_taken <= i_was_taken;
            r_fwd_ctr  <= upd_ctr;
        end
        if (s1_go) begin
            r_out_pred <= ctr_taken(cur_ctr);
        end
    end

    assign o_valid         = r_out_vld;
    assign o_predict_taken = r_out_pred;

    // no request sits in the pipe while the table is cleared
    a_clr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_act |-> !r_s1_vld && !accept)
        else $error("request in flight during clearing pass");

    // a bypass is only armed for a request waiting on its counter
    a_fwd_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_vld |-> r_s1_vld)
        else $error("bypass armed with no request in stage one");

    // a request leaving stage one lands in the output register
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> r_out_vld)
        else $error("request lost between stage one and output");

    // a held request in stage one does not update the table
    a_hold_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !adv) |-> !ram_we)
        else $error("table written while stage one is held");

endmodule

`default_nettype wire
